>>> sv/pba_pkg.sv
// Shared constants, types and codes for the page bitmap allocator.
package pba_pkg;

   localparam int NUM_PAGES     = 512;
   localparam int MAP_WORD_BITS = 8;
   localparam int ATTR_BITS     = 16;

   localparam int MAP_WORDS  = (NUM_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WORD_IDX_W = $clog2(MAP_WORDS);
   localparam int BIT_W      = $clog2(MAP_WORD_BITS);

   // Summary search is two levels: groups of GRP_SIZE map words.
   localparam int GRP_SIZE  = 8;
   localparam int GOFF_W    = $clog2(GRP_SIZE);
   localparam int NUM_GRPS  = MAP_WORDS / GRP_SIZE;
   localparam int GRP_W     = WORD_IDX_W - GOFF_W;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int PAGE_W   = 9;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 10;

   localparam logic [COUNT_W-1:0] MAX_PAGES = COUNT_W'(NUM_PAGES);

   // Commands
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE    = 2'd2;

   // Internal operation codes after classification
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RESERVE = 2'd1;
   localparam logic [1:0] OP_FREE    = 2'd2;
   localparam logic [1:0] OP_REJECT  = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_USED       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FREE_RANGE = 3'd4;

   typedef struct packed {
      logic [1:0]           op;
      logic [PAGE_W-1:0]    page;
      logic [ATTR_BITS-1:0] attr;
      logic [STATUS_W-1:0]  rej_status;
   } job_type;

endpackage

>>> sv/pba_fifo.sv
// Two-entry queue of classified jobs between the front and back ends.
module pba_fifo import pba_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head_job,
   output logic    empty
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> sv/pba_front.sv
// Front end: page count register, request intake and command classification.
module pba_front import pba_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [PAGE_W-1:0]    req_page_index,
   input  logic [ATTR_BITS-1:0] req_attr,
   input  logic                 csr_wr_en,
   input  logic [COUNT_W-1:0]   csr_wr_data,
   input  logic                 q_full,
   output logic                 q_push,
   output job_type              q_job,
   output logic [COUNT_W-1:0]   limit
);

   logic [COUNT_W-1:0] total_pages_ff, total_pages_in;
   logic               in_range;

   assign total_pages_in = csr_wr_en ? csr_wr_data : total_pages_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_pages_ff <= MAX_PAGES;
      end else begin
         total_pages_ff <= total_pages_in;
      end
   end

   assign limit    = (total_pages_ff > MAX_PAGES) ? MAX_PAGES : total_pages_ff;
   assign in_range = {1'b0, req_page_index} < limit;
   assign q_push   = req_push && !q_full;

   always_comb begin
      q_job.page       = req_page_index;
      q_job.attr       = req_attr;
      q_job.op         = OP_REJECT;
      q_job.rej_status = ST_RANGE;
      case (req_command)
         CMD_ALLOC: begin
            q_job.op = OP_ALLOC;
         end
         CMD_RESERVE: begin
            if (in_range) begin
               q_job.op = OP_RESERVE;
            end
         end
         CMD_FREE: begin
            if (in_range) begin
               q_job.op = OP_FREE;
            end else begin
               q_job.rej_status = ST_FREE_RANGE;
            end
         end
         default: begin
            q_job.op = OP_REJECT;
         end
      endcase
   end

endmodule

>>> sv/pba_back.sv
// Back end: used-bit map, attribute store, used count and result register.
module pba_back import pba_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [COUNT_W-1:0]   limit,
   input  job_type              q_job,
   input  logic                 q_empty,
   output logic                 q_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic [PAGE_W-1:0]    rsp_result_page,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [COUNT_W-1:0]   rsp_free_pages
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_GRP  = 3'd1;
   localparam logic [2:0] S_WRD  = 3'd2;
   localparam logic [2:0] S_READ = 3'd3;
   localparam logic [2:0] S_EXEC = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]               state_ff, state_in;
   job_type                  job_ff;
   logic [WORD_IDX_W-1:0]    word_ff, word_in;
   logic [GRP_W-1:0]         grp_ff, grp_in;
   logic [COUNT_W-1:0]       used_count_ff, used_count_in;
   logic [MAP_WORDS-1:0]     word_vld_ff, word_vld_in;
   logic [MAP_WORDS-1:0]     full_ff, full_in;
   logic [PAGE_W-1:0]        res_page_ff, res_page_in;
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;
   logic                     rsp_vld_ff, rsp_vld_in;
   logic [PAGE_W-1:0]        out_page_ff;
   logic [STATUS_W-1:0]      out_status_ff;
   logic [COUNT_W-1:0]       out_free_ff;

   logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [ATTR_BITS-1:0]     attr_mem [NUM_PAGES];
   logic [MAP_WORD_BITS-1:0] rd_data_ff;
   logic                     rd_vld_ff;

   logic                     rd_en;
   logic                     map_we;
   logic [MAP_WORD_BITS-1:0] map_wdata;
   logic                     attr_we;
   logic [PAGE_W-1:0]        attr_addr;

   logic [NUM_GRPS-1:0]      grp_nf;
   logic                     grp_found;
   logic [GRP_W-1:0]         grp_first;
   logic [GRP_SIZE-1:0]      grp_full;
   logic [GOFF_W-1:0]        off_first;
   logic [MAP_WORD_BITS-1:0] word_data;
   logic                     zero_found;
   logic [BIT_W-1:0]         zero_bit;
   logic [BIT_W-1:0]         bit_sel;
   logic [PAGE_W-1:0]        page_q;
   logic                     bit_used;
   logic                     out_free;
   logic [COUNT_W-1:0]       avail_count;

   // Group and word summary search
   always_comb begin
      for (int g = 0; g < NUM_GRPS; g++) begin
         grp_nf[g] = ~&full_ff[g*GRP_SIZE +: GRP_SIZE];
      end
      grp_found = |grp_nf;
      grp_first = '0;
      for (int g = NUM_GRPS - 1; g >= 0; g--) begin
         if (grp_nf[g]) begin
            grp_first = GRP_W'(g);
         end
      end
      grp_full  = full_ff[{grp_ff, {GOFF_W{1'b0}}} +: GRP_SIZE];
      off_first = '0;
      for (int k = GRP_SIZE - 1; k >= 0; k--) begin
         if (!grp_full[k]) begin
            off_first = GOFF_W'(k);
         end
      end
   end

   // Bit-level decode of the fetched map word
   always_comb begin
      word_data  = rd_vld_ff ? rd_data_ff : '0;
      zero_found = ~&word_data;
      zero_bit   = '0;
      for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
         if (!word_data[b]) begin
            zero_bit = BIT_W'(b);
         end
      end
      bit_sel  = (job_ff.op == OP_ALLOC) ? zero_bit : job_ff.page[BIT_W-1:0];
      page_q   = {word_ff, bit_sel};
      bit_used = word_data[bit_sel];
   end

   assign out_free    = !rsp_vld_ff || rsp_pop;
   assign avail_count = (limit > used_count_ff) ? (limit - used_count_ff) : '0;

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      grp_in        = grp_ff;
      used_count_in = used_count_ff;
      word_vld_in   = word_vld_ff;
      full_in       = full_ff;
      res_page_in   = res_page_ff;
      res_status_in = res_status_ff;
      q_pop         = 1'b0;
      rd_en         = 1'b0;
      map_we        = 1'b0;
      map_wdata     = word_data;
      attr_we       = 1'b0;
      attr_addr     = page_q;
      rsp_vld_in    = rsp_vld_ff;
      if (rsp_pop && rsp_vld_ff) begin
         rsp_vld_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               word_in = q_job.page[PAGE_W-1:BIT_W];
               case (q_job.op)
                  OP_ALLOC: begin
                     state_in = S_GRP;
                  end
                  OP_RESERVE, OP_FREE: begin
                     state_in = S_READ;
                  end
                  default: begin
                     res_page_in   = '0;
                     res_status_in = q_job.rej_status;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end
         S_GRP: begin
            if (grp_found) begin
               grp_in   = grp_first;
               state_in = S_WRD;
            end else begin
               res_page_in   = '0;
               res_status_in = ST_FULL;
               state_in      = S_DONE;
            end
         end
         S_WRD: begin
            word_in  = {grp_ff, off_first};
            state_in = S_READ;
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (job_ff.op)
               OP_ALLOC: begin
                  if (zero_found && ({1'b0, page_q} < limit)) begin
                     map_we        = 1'b1;
                     map_wdata     = word_data | (MAP_WORD_BITS'(1) << bit_sel);
                     attr_we       = 1'b1;
                     used_count_in = used_count_ff + COUNT_W'(1);
                     res_page_in   = page_q;
                     res_status_in = ST_OK;
                  end else begin
                     res_page_in   = '0;
                     res_status_in = ST_FULL;
                  end
               end
               OP_RESERVE: begin
                  if (bit_used) begin
                     res_page_in   = '0;
                     res_status_in = ST_USED;
                  end else begin
                     map_we        = 1'b1;
                     map_wdata     = word_data | (MAP_WORD_BITS'(1) << bit_sel);
                     attr_we       = 1'b1;
                     used_count_in = used_count_ff + COUNT_W'(1);
                     res_page_in   = page_q;
                     res_status_in = ST_OK;
                  end
               end
               default: begin
                  // free: a page already free reports success, count unchanged
                  if (bit_used) begin
                     map_we    = 1'b1;
                     map_wdata = word_data & ~(MAP_WORD_BITS'(1) << bit_sel);
                     if (used_count_ff != '0) begin
                        used_count_in = used_count_ff - COUNT_W'(1);
                     end
                  end
                  res_page_in   = page_q;
                  res_status_in = ST_OK;
               end
            endcase
            if (map_we) begin
               word_vld_in[word_ff] = 1'b1;
               full_in[word_ff]     = &map_wdata;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_count_ff <= '0;
         word_vld_ff   <= '0;
         full_ff       <= '0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_count_ff <= used_count_in;
         word_vld_ff   <= word_vld_in;
         full_ff       <= full_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_job;
      end
      word_ff       <= word_in;
      grp_ff        <= grp_in;
      res_page_ff   <= res_page_in;
      res_status_ff <= res_status_in;
      if (state_ff == S_DONE && out_free) begin
         out_page_ff   <= res_page_ff;
         out_status_ff <= res_status_ff;
         out_free_ff   <= avail_count;
      end
   end

   // Map word memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[word_ff] <= map_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= map_mem[word_ff];
         rd_vld_ff  <= word_vld_ff[word_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (attr_we) begin
         attr_mem[attr_addr] <= job_ff.attr;
      end
   end

   assign rsp_empty       = !rsp_vld_ff;
   assign rsp_result_page = out_page_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_free_pages  = out_free_ff;

endmodule

>>> sv/page_bitmap_allocator.sv
// Top level of the first-fit page bitmap allocator.
// Requests enter a two-entry queue and are executed one at a time by the back
// end, which keeps the used-bit map in a 64 x 8 word memory plus per-word valid
// and full summary bits. Reserve and free run map read, update and result;
// allocate first runs a group search and a word search. The map memory read
// is registered. An unused command code or a reserve/free beyond the managed
// page count goes straight to the result. The result register lets the next
// transaction start while a result waits to be popped. total_pages is
// read by the front and back ends, so write it only while the block is idle.
module page_bitmap_allocator import pba_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [PAGE_W-1:0]    req_page_index,
   input  logic [ATTR_BITS-1:0] req_attr,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [PAGE_W-1:0]    rsp_result_page,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [COUNT_W-1:0]   rsp_free_pages,
   input  logic                 csr_wr_en,
   input  logic [COUNT_W-1:0]   csr_wr_data
);

   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_empty;
   job_type            front_job;
   job_type            head_job;
   logic [COUNT_W-1:0] limit;

   assign req_full = q_full;

   pba_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_command    (req_command),
      .req_page_index (req_page_index),
      .req_attr       (req_attr),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_job          (front_job),
      .limit          (limit)
   );

   pba_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (front_job),
      .full     (q_full),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty)
   );

   pba_back u_back (
      .clock           (clock),
      .reset           (reset),
      .limit           (limit),
      .q_job           (head_job),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_result_page (rsp_result_page),
      .rsp_status      (rsp_status),
      .rsp_free_pages  (rsp_free_pages)
   );

   // A failed transaction always reports page zero.
   a_fail_page_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != ST_OK) |-> (rsp_result_page == '0))
      else $error("failed transaction reports nonzero page");

   // Free count never exceeds the managed page count.
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_free_pages <= limit))
      else $error("free page count above managed pages");

   // Only defined status codes reach the result port.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_status <= ST_FREE_RANGE))
      else $error("undefined status code");

endmodule

>>> verif/tb_page_bitmap_allocator.sv
// Self-checking testbench for page_bitmap_allocator: directed and random requests vs a bitmap model.
module tb_page_bitmap_allocator;
   import pba_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 4000;
   localparam int LONG_HOLD  = 400;
   localparam int SETTLE     = 12;

   typedef struct {
      logic [CMD_W-1:0]     command;
      logic [PAGE_W-1:0]    page_index;
      logic [ATTR_BITS-1:0] attr;
   } page_req_type;

   typedef struct {
      logic [PAGE_W-1:0]   page;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  free_pages;
   } page_outcome_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [CMD_W-1:0]     req_command = '0;
   logic [PAGE_W-1:0]    req_page_index = '0;
   logic [ATTR_BITS-1:0] req_attr = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [PAGE_W-1:0]    rsp_result_page;
   logic [STATUS_W-1:0]  rsp_status;
   logic [COUNT_W-1:0]   rsp_free_pages;
   logic                 csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]   csr_wr_data = '0;

   // bitmap model state
   logic [NUM_PAGES-1:0] page_used = '0;
   int                   pages_in_use = 0;
   logic [COUNT_W-1:0]   total_pages_reg = MAX_PAGES;
   int                   gen_limit = NUM_PAGES;

   page_req_type         queued_requests[$];
   page_outcome_type     expected_outcomes[$];
   int                   errors = 0;
   int                   idle_cycles = 0;
   int                   holds_requested = 0;
   int                   holds_done = 0;

   page_bitmap_allocator DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_page_index  (req_page_index),
      .req_attr        (req_attr),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_result_page (rsp_result_page),
      .rsp_status      (rsp_status),
      .rsp_free_pages  (rsp_free_pages),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Applies one request to the bitmap model and returns the result it should give.
   function automatic page_outcome_type apply_request(page_req_type rq);
      int               lim;
      int               q;
      page_outcome_type o;
      lim = (total_pages_reg > MAX_PAGES) ? NUM_PAGES : int'(total_pages_reg);
      o.page   = '0;
      o.status = ST_RANGE;
      case (rq.command)
         CMD_ALLOC: begin
            o.status = ST_FULL;
            for (q = 0; q < lim; q++) begin
               if (!page_used[q]) begin
                  page_used[q] = 1'b1;
                  pages_in_use++;
                  o.page   = PAGE_W'(q);
                  o.status = ST_OK;
                  break;
               end
            end
         end
         CMD_RESERVE: begin
            if (int'(rq.page_index) >= lim) begin
               o.status = ST_RANGE;
            end else if (page_used[rq.page_index]) begin
               o.status = ST_USED;
            end else begin
               page_used[rq.page_index] = 1'b1;
               pages_in_use++;
               o.page   = rq.page_index;
               o.status = ST_OK;
            end
         end
         CMD_FREE: begin
            if (int'(rq.page_index) >= lim) begin
               o.status = ST_FREE_RANGE;
            end else begin
               if (page_used[rq.page_index]) begin
                  page_used[rq.page_index] = 1'b0;
                  if (pages_in_use > 0) pages_in_use--;
               end
               o.page   = rq.page_index;
               o.status = ST_OK;
            end
         end
         default: ;
      endcase
      // pages above a shrunk limit stay counted, so this can saturate
      o.free_pages = (lim > pages_in_use) ? COUNT_W'(lim - pages_in_use) : '0;
      return o;
   endfunction

   // Sender: bursts of random length, random gaps in between.
   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (gap_left > 0) begin
         gap_left--;
         req_push <= 1'b0;
      end else if (queued_requests.size() != 0) begin
         req_push       <= 1'b1;
         req_command    <= queued_requests[0].command;
         req_page_index <= queued_requests[0].page_index;
         req_attr       <= queued_requests[0].attr;
         if (burst_left == 0) burst_left = $urandom_range(1, 40);
         burst_left--;
         if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
         req_push <= 1'b0;
      end
   end

   // Receiver: random stall pattern whose mode changes at random; long holds on request.
   int hold_left = 0;
   int pop_mode  = 0;
   int mode_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
         if (hold_left == 0) holds_done++;
      end else if (holds_done < holds_requested) begin
         hold_left = LONG_HOLD;
         rsp_pop <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            pop_mode  = $urandom_range(0, 3);
            mode_left = $urandom_range(5, 80);
         end
         mode_left--;
         case (pop_mode)
            0:       rsp_pop <= 1'b1;
            1:       rsp_pop <= ($urandom_range(0, 1) == 0);
            2:       rsp_pop <= ($urandom_range(0, 3) == 0);
            default: rsp_pop <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Results are checked before this edge's input transaction enters the model.
   always @(posedge clock) begin
      page_outcome_type exp_o;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_outcomes.size() == 0) begin
            $error("result with nothing expected: page %0d status %0d free %0d",
                   rsp_result_page, rsp_status, rsp_free_pages);
            errors++;
         end else begin
            exp_o = expected_outcomes.pop_front();
            if (rsp_result_page !== exp_o.page) begin
               $error("result_page mismatch: expected %0d, actual %0d", exp_o.page,
                      rsp_result_page);
               errors++;
            end
            if (rsp_status !== exp_o.status) begin
               $error("status mismatch: expected %0d, actual %0d", exp_o.status, rsp_status);
               errors++;
            end
            if (rsp_free_pages !== exp_o.free_pages) begin
               $error("free_pages mismatch: expected %0d, actual %0d", exp_o.free_pages,
                      rsp_free_pages);
               errors++;
            end
         end
      end
      if (!reset && req_push && !req_full)
         expected_outcomes.push_back(apply_request(queued_requests.pop_front()));

      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic add_req(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] page,
                          logic [ATTR_BITS-1:0] attr);
      page_req_type rq;
      rq.command    = cmd;
      rq.page_index = page;
      rq.attr       = attr;
      queued_requests.push_back(rq);
   endtask

   // Mostly in-range targets so reserve and free hit live pages.
   task automatic add_random(int n, int alloc_pct);
      page_req_type rq;
      int           r;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < alloc_pct) rq.command = CMD_ALLOC;
         else if (r < alloc_pct + 25) rq.command = CMD_RESERVE;
         else if (r < 97) rq.command = CMD_FREE;
         else rq.command = CMD_UNUSED;
         if (gen_limit > 0 && $urandom_range(0, 9) != 0)
            rq.page_index = PAGE_W'($urandom_range(0, gen_limit - 1));
         else
            rq.page_index = PAGE_W'($urandom);
         rq.attr = ATTR_BITS'($urandom);
         queued_requests.push_back(rq);
      end
   endtask

   task automatic wait_idle();
      while (queued_requests.size() != 0 || expected_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_total_pages(logic [COUNT_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      total_pages_reg = value;
      gen_limit = (value > MAX_PAGES) ? NUM_PAGES : int'(value);
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // full range at reset value: first fit, double reserve, double free, unused code
      add_req(CMD_ALLOC,   9'd0,   16'h0000);
      add_req(CMD_ALLOC,   9'd511, 16'hFFFF);
      add_req(CMD_RESERVE, 9'd511, 16'hFFFF);
      add_req(CMD_RESERVE, 9'd511, 16'h0000);
      add_req(CMD_RESERVE, 9'd0,   16'h5A5A);
      add_req(CMD_FREE,    9'd0,   16'h0000);
      add_req(CMD_FREE,    9'd0,   16'hFFFF);
      add_req(CMD_ALLOC,   9'd0,   16'hA5A5);
      add_req(CMD_FREE,    9'd511, 16'h0000);
      add_req(CMD_UNUSED,  9'd511, 16'hFFFF);
      add_req(CMD_RESERVE, 9'd2,   16'h1234);
      wait_idle();

      // no pages managed
      set_total_pages(10'd0);
      add_req(CMD_ALLOC,   9'd0,   16'hFFFF);
      add_req(CMD_RESERVE, 9'd0,   16'h0001);
      add_req(CMD_FREE,    9'd511, 16'h0000);
      add_req(CMD_UNUSED,  9'd0,   16'h0000);
      wait_idle();

      // eight pages: out-of-range targets, then allocate until exhausted
      set_total_pages(10'd8);
      add_req(CMD_RESERVE, 9'd8, 16'h00FF);
      add_req(CMD_FREE,    9'd8, 16'hFF00);
      repeat (6) add_req(CMD_ALLOC, 9'd0, 16'hBEEF);
      add_req(CMD_RESERVE, 9'd7, 16'h0F0F);
      wait_idle();

      // receiver holds off while the sender keeps pushing: input must back up
      set_total_pages(10'd512);
      holds_requested++;
      add_random(300, 40);
      wait_idle();

      set_total_pages(10'd64);
      add_random(300, 60);
      wait_idle();

      set_total_pages(10'd37);
      holds_requested++;
      add_random(200, 45);
      wait_idle();

      // largest register value is clamped to the page count
      set_total_pages(10'd1023);
      add_random(200, 55);
      wait_idle();

      // shrink below the used count: free count pinned at zero until pages come back
      set_total_pages(10'd16);
      add_random(150, 40);
      wait_idle();

      set_total_pages(10'd1);
      add_random(100, 40);
      wait_idle();

      set_total_pages(10'd600);
      add_random(250, 50);
      wait_idle();

      if (errors == 0 && expected_outcomes.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> files.f
sv/pba_pkg.sv
sv/pba_fifo.sv
sv/pba_front.sv
sv/pba_back.sv
sv/page_bitmap_allocator.sv
verif/tb_page_bitmap_allocator.sv
